[sv/tdsf_pkg.sv]
package tdsf_pkg;

	// Glyph indexes into the segment table
	localparam logic [4:0] GLYPH_F     = 5'd15;
	localparam logic [4:0] GLYPH_BLANK = 5'd16;

	// Displayable limits per mode
	localparam logic [15:0] NUM_MAX  = 16'd999;
	localparam logic [15:0] FUNC_MAX = 16'd99;

	// Mode codes
	localparam logic MODE_NUM  = 1'b0;
	localparam logic MODE_FUNC = 1'b1;

	// Digit select codes
	localparam logic [2:0] SEL_UNITS = 3'b001;
	localparam logic [2:0] SEL_TENS  = 3'b010;
	localparam logic [2:0] SEL_HUND  = 3'b100;
	localparam logic [2:0] SEL_ALL   = 3'b111;

	// Request beat
	typedef struct packed {
		logic        mode;
		logic [15:0] value;
	} in_t;

	// Result beat
	typedef struct packed {
		logic [7:0] segments;
		logic [2:0] digit_select;
		logic       is_error;
		logic       last;
	} out_t;

	// Decimal digits after the split stages
	typedef struct packed {
		logic       err;
		logic       mode;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digit_t;

	// Segment patterns ready for the serializer
	typedef struct packed {
		logic       err;
		logic [7:0] seg_u;
		logic [7:0] seg_t;
		logic [7:0] seg_h;
	} seg_t;

	// Fixed glyph table; index 16 and above is the blank pattern
	function automatic logic [7:0] glyph_seg(input logic [4:0] g);
		logic [7:0] s;
		case (g)
			5'd0:    s = 8'h28;
			5'd1:    s = 8'hee;
			5'd2:    s = 8'h32;
			5'd3:    s = 8'ha2;
			5'd4:    s = 8'he4;
			5'd5:    s = 8'ha1;
			5'd6:    s = 8'h21;
			5'd7:    s = 8'hea;
			5'd8:    s = 8'h20;
			5'd9:    s = 8'ha0;
			5'd10:   s = 8'h60;
			5'd11:   s = 8'h25;
			5'd12:   s = 8'h39;
			5'd13:   s = 8'h26;
			5'd14:   s = 8'h31;
			5'd15:   s = 8'h71;
			default: s = 8'hff;
		endcase
		return s;
	endfunction

endpackage

[sv/three_digit_seven_segment_formatter_unit.sv]
// Path: a request passes stage 1, stage 2, stage 3, stage 4 and the serializer's output register before its first beat.
// Throughput: one beat per cycle while a request's beats go out.
// Sustained rate is set by the output serializer, which owes three beats per displayable request and one per error.
// busy is high while stage 1 holds a request that the stalled pipeline cannot move on.
// Reset (arst_n low) clears all valid bits and the serializer.
module three_digit_seven_segment_formatter_unit import tdsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  req,
	output logic strobe,
	output out_t result
);

	logic   ready_in;
	logic   dig_valid, dig_ready;
	digit_t dig;
	logic   seg_valid, seg_ready;
	seg_t   seg;

	assign busy = !ready_in;

	// Stages 1-3: range check and decimal split
	tdsf_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.req       (req),
		.ready_out (ready_in),
		.dig_valid (dig_valid),
		.dig       (dig),
		.dig_ready (dig_ready)
	);

	// Stage 4: blanking and segment lookup
	tdsf_glyph u_glyph (
		.clk       (clk),
		.arst_n    (arst_n),
		.dig_valid (dig_valid),
		.dig       (dig),
		.dig_ready (dig_ready),
		.seg_valid (seg_valid),
		.seg       (seg),
		.seg_ready (seg_ready)
	);

	// Output serializer
	tdsf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg       (seg),
		.seg_ready (seg_ready),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

[sv/tdsf_digits.sv]
module tdsf_digits import tdsf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  in_t    req,
	output logic   ready_out,
	output logic   dig_valid,
	output digit_t dig,
	input  logic   dig_ready
);

	logic       v_s1, v_s2, v_s3;
	logic       err_s1, err_s2;
	logic       mode_s1, mode_s2;
	logic [9:0] val_s1, val_s2;
	logic [3:0] hund_s2;
	logic [6:0] q10_s2;
	digit_t     dig_s3;
	logic       adv1, adv2, adv3;
	logic       err_c;
	logic [15:0] prod_h;
	logic [17:0] prod_t;
	logic [9:0]  units_w;
	logic [6:0]  tens_w;

	// Stall chain: a stage moves when it is empty or its successor moves
	assign adv3      = !v_s3 || dig_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign ready_out = adv1;

	// Range check against the mode's limit
	assign err_c = (req.mode == MODE_FUNC) ? (req.value > FUNC_MAX) : (req.value > NUM_MAX);

	// Reciprocal multiplies, exact for values below 1000
	assign prod_h = {6'd0, val_s1} * 16'd41;
	assign prod_t = {8'd0, val_s1} * 18'd205;

	// Remainders from the quotients
	assign units_w = val_s2 - ({3'd0, q10_s2} * 10'd10);
	assign tens_w  = q10_s2 - ({3'd0, hund_s2} * 7'd10);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: capture and range check
	always_ff @(posedge clk) begin
		if (adv1) begin
			err_s1  <= err_c;
			mode_s1 <= req.mode;
			val_s1  <= req.value[9:0];
		end
	end

	// Stage 2: hundreds and value / 10
	always_ff @(posedge clk) begin
		if (adv2) begin
			err_s2  <= err_s1;
			mode_s2 <= mode_s1;
			val_s2  <= val_s1;
			hund_s2 <= prod_h[15:12];
			q10_s2  <= prod_t[17:11];
		end
	end

	// Stage 3: tens and units
	always_ff @(posedge clk) begin
		if (adv3) begin
			dig_s3.err   <= err_s2;
			dig_s3.mode  <= mode_s2;
			dig_s3.hund  <= hund_s2;
			dig_s3.tens  <= tens_w[3:0];
			dig_s3.units <= units_w[3:0];
		end
	end

	assign dig_valid = v_s3;
	assign dig       = dig_s3;

endmodule

[sv/tdsf_glyph.sv]
module tdsf_glyph import tdsf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   dig_valid,
	input  digit_t dig,
	output logic   dig_ready,
	output logic   seg_valid,
	output seg_t   seg,
	input  logic   seg_ready
);

	logic       v_s4;
	seg_t       seg_s4;
	logic       adv4;
	logic       hund_zero, tens_blank;
	logic [4:0] g_h, g_t, g_u;

	assign adv4      = !v_s4 || seg_ready;
	assign dig_ready = adv4;

	// Leading-zero blanking in number mode, F prefix in function mode
	assign hund_zero  = (dig.hund == 4'd0);
	assign tens_blank = (dig.mode == MODE_NUM) && hund_zero && (dig.tens == 4'd0);
	assign g_u = {1'b0, dig.units};
	assign g_t = tens_blank ? GLYPH_BLANK : {1'b0, dig.tens};
	assign g_h = (dig.mode == MODE_FUNC) ? GLYPH_F :
	             (hund_zero ? GLYPH_BLANK : {1'b0, dig.hund});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= dig_valid;
		end
	end

	// Stage 4: table lookup
	always_ff @(posedge clk) begin
		if (adv4) begin
			seg_s4.err   <= dig.err;
			seg_s4.seg_u <= glyph_seg(g_u);
			seg_s4.seg_t <= glyph_seg(g_t);
			seg_s4.seg_h <= glyph_seg(g_h);
		end
	end

	assign seg_valid = v_s4;
	assign seg       = seg_s4;

endmodule

[sv/tdsf_ser.sv]
module tdsf_ser import tdsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	input  seg_t seg,
	output logic seg_ready,
	output logic strobe,
	output out_t result
);

	logic [1:0] rem_cnt_q;
	logic       strobe_q;
	out_t       result_q;
	logic [7:0] seg_t_q, seg_h_q;
	logic       load;

	// Take a new request only once the previous one has fully gone out
	assign seg_ready = (rem_cnt_q == 2'd0);
	assign load      = seg_valid && seg_ready;

	// Control: beat strobe and beats still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_cnt_q <= 2'd0;
			strobe_q  <= 1'b0;
		end else begin
			if (rem_cnt_q != 2'd0) begin
				rem_cnt_q <= rem_cnt_q - 2'd1;
				strobe_q  <= 1'b1;
			end else if (load) begin
				rem_cnt_q <= seg.err ? 2'd0 : 2'd2;
				strobe_q  <= 1'b1;
			end else begin
				strobe_q  <= 1'b0;
			end
		end
	end

	// Output beat: units, then tens, then hundreds; error is one beat
	always_ff @(posedge clk) begin
		if (rem_cnt_q == 2'd2) begin
			result_q.segments     <= seg_t_q;
			result_q.digit_select <= SEL_TENS;
			result_q.is_error     <= 1'b0;
			result_q.last         <= 1'b0;
		end else if (rem_cnt_q == 2'd1) begin
			result_q.segments     <= seg_h_q;
			result_q.digit_select <= SEL_HUND;
			result_q.is_error     <= 1'b0;
			result_q.last         <= 1'b1;
		end else if (load) begin
			seg_t_q <= seg.seg_t;
			seg_h_q <= seg.seg_h;
			if (seg.err) begin
				result_q.segments     <= glyph_seg(GLYPH_F);
				result_q.digit_select <= SEL_ALL;
				result_q.is_error     <= 1'b1;
				result_q.last         <= 1'b1;
			end else begin
				result_q.segments     <= seg.seg_u;
				result_q.digit_select <= SEL_UNITS;
				result_q.is_error     <= 1'b0;
				result_q.last         <= 1'b0;
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Owed beats always follow on the next cycle
	a_owed_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rem_cnt_q != 2'd0 |=> strobe_q)
		else $error("owed beat missing");

	// Digit beats carry a single select bit
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.is_error |-> $onehot(result_q.digit_select))
		else $error("digit select not one-hot");

	// Error beat closes its request
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.is_error |-> result_q.last &&
		result_q.digit_select == SEL_ALL)
		else $error("error beat malformed");

	// Last digit beat is the hundreds position
	a_last_hund: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last && !result_q.is_error |->
		result_q.digit_select == SEL_HUND)
		else $error("last beat not hundreds");

endmodule
